>>> hdl/deq_pkg.sv
// shared types, opcodes and status codes of the double-ended queue engine
`timescale 1ns / 1ps
`default_nettype none

package deq_pkg;

   localparam int unsigned DATA_W        = 32;
   localparam int unsigned OP_W          = 3;
   localparam int unsigned STATUS_W      = 2;
   localparam int unsigned DEPTH_DEFAULT = 1024;

   // response buffer: one beat in flight plus two waiting
   localparam int unsigned RSP_DEPTH = 3;
   localparam int unsigned RSP_IDX_W = $clog2(RSP_DEPTH);
   localparam int unsigned RSP_CNT_W = $clog2(RSP_DEPTH + 1);

   localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
   localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
   localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
   localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
   localparam logic [OP_W-1:0] OP_SIZE       = 3'd4;
   localparam logic [OP_W-1:0] OP_EMPTY      = 3'd5;
   localparam logic [OP_W-1:0] OP_FRONT      = 3'd6;
   localparam logic [OP_W-1:0] OP_BACK       = 3'd7;

   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [DATA_W-1:0]   value;
   } rsp_beat_type;

endpackage

`default_nettype wire

>>> hdl/deq_rsp_fifo.sv
// three-entry response buffer between the queue store and the result channel
`timescale 1ns / 1ps
`default_nettype none

module deq_rsp_fifo
   import deq_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_valid,
   input  wire rsp_beat_type         in_beat,
   output logic                      out_valid,
   input  wire logic                 out_ready,
   output rsp_beat_type              out_beat,
   output logic [RSP_CNT_W-1:0]      count
);

   localparam logic [RSP_IDX_W-1:0] LAST_IDX = RSP_IDX_W'(RSP_DEPTH - 1);
   localparam logic [RSP_CNT_W-1:0] FULL_CNT = RSP_CNT_W'(RSP_DEPTH);

   rsp_beat_type           beat_ff [RSP_DEPTH];
   logic [RSP_IDX_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [RSP_IDX_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [RSP_CNT_W-1:0]   count_ff, count_in;
   logic                   pop;

   assign out_valid = (count_ff != '0);
   assign out_beat  = beat_ff[rd_ptr_ff];
   assign count     = count_ff;
   assign pop       = out_valid & out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (in_valid) begin
         wr_ptr_in = (wr_ptr_ff == LAST_IDX) ? '0 : wr_ptr_ff + RSP_IDX_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_IDX) ? '0 : rd_ptr_ff + RSP_IDX_W'(1);
      end
      if (in_valid && !pop) begin
         count_in = count_ff + RSP_CNT_W'(1);
      end else if (!in_valid && pop) begin
         count_in = count_ff - RSP_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid) begin
         beat_ff[wr_ptr_ff] <= in_beat;
      end
   end

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_CNT)
      else $error("response buffer count out of range");

   a_no_overflow : assert property (@(posedge clock) disable iff (reset)
      in_valid |-> (count_ff != FULL_CNT) || pop)
      else $error("response buffer written while full");

endmodule

`default_nettype wire

>>> hdl/double_ended_queue_engine.sv
// top level of the double-ended queue engine: pointers, entry store and request decode
//
// Request channel: req_tuser carries the operation (push front, push back, pop
// front, pop back, size, empty, peek front, peek back) and req_tdata the word
// to push. Result channel: rsp_tdata carries the popped or peeked word, the
// size or the empty flag, rsp_tuser the status (ok, queue empty, push dropped
// because full). A successful push gives no result beat; every other request
// gives exactly one, in request order.
// Throughput: one request per cycle while req_tready is high. The entry store has
// a single port that each request uses for at most one read or one write, and the
// head pointer and count are updated in the accepting cycle, so back-to-back
// requests never touch the store at the same time.
// The result beat is registered together with the store read, then passes through
// the response buffer before it is offered.
// Reset empties the queue at once: head and count go to zero; the store is not
// cleared, as only entries written since are ever read.
// When the result receiver stalls, up to three result beats are held; req_tready
// drops once the buffer plus the beat in flight would fill it.
`timescale 1ns / 1ps
`default_nettype none

module double_ended_queue_engine
   import deq_pkg::*;
#(
   parameter int unsigned DEPTH = DEPTH_DEFAULT
)
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   input  wire logic [DATA_W-1:0]    req_tdata,   // [31:0] push_value
   input  wire logic [OP_W-1:0]      req_tuser,   // [2:0] req_type
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   output logic [DATA_W-1:0]         rsp_tdata,   // [31:0] result_value
   output logic [STATUS_W-1:0]       rsp_tuser    // [1:0] status
);

   localparam int unsigned IDX_W = $clog2(DEPTH);
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);
   localparam logic [IDX_W:0]   WRAP_SUM = (IDX_W + 1)'(DEPTH);

   logic [DATA_W-1:0]    store_mem [DEPTH];
   logic [DATA_W-1:0]    rd_data_ff;

   logic [IDX_W-1:0]     head_ff, head_in;
   logic [CNT_W-1:0]     occ_ff, occ_in;
   logic                 s1_valid_ff, s1_valid_in;
   logic                 s1_from_mem_ff, s1_from_mem_in;
   rsp_beat_type         s1_beat_ff, s1_beat_in;

   logic [OP_W-1:0]      op;
   logic                 req_fire;
   logic                 is_empty, is_full;
   logic [CNT_W-1:0]     occ_dec;
   logic [IDX_W-1:0]     back_off;
   logic [IDX_W:0]       back_sum;
   logic [IDX_W-1:0]     back_slot;
   logic [IDX_W-1:0]     head_dec, head_inc;
   logic                 mem_we, mem_re;
   logic [IDX_W-1:0]     mem_addr;

   rsp_beat_type         fifo_in_beat, fifo_out_beat;
   logic [RSP_CNT_W-1:0] fifo_count;
   logic [RSP_CNT_W:0]   credit_sum;

   assign op       = req_tuser;
   assign req_fire = req_tvalid & req_tready;
   assign is_empty = (occ_ff == '0);
   assign is_full  = (occ_ff == FULL_CNT);
   assign occ_dec  = occ_ff - CNT_W'(1);

   // back slot: at the count for a push, one before it for a pop or peek
   assign back_off  = (op == OP_PUSH_BACK) ? occ_ff[IDX_W-1:0] : occ_dec[IDX_W-1:0];
   assign back_sum  = {1'b0, head_ff} + {1'b0, back_off};
   assign back_slot = (back_sum >= WRAP_SUM) ? IDX_W'(back_sum - WRAP_SUM)
                                             : back_sum[IDX_W-1:0];
   assign head_dec  = (head_ff == '0) ? LAST_IDX : head_ff - IDX_W'(1);
   assign head_inc  = (head_ff == LAST_IDX) ? '0 : head_ff + IDX_W'(1);

   always_comb begin
      head_in        = head_ff;
      occ_in         = occ_ff;
      mem_we         = 1'b0;
      mem_re         = 1'b0;
      mem_addr       = head_ff;
      s1_valid_in    = 1'b0;
      s1_from_mem_in = 1'b0;
      s1_beat_in     = '{status: ST_OK, value: '0};
      if (req_fire) begin
         case (op)
            OP_PUSH_FRONT, OP_PUSH_BACK: begin
               if (is_full) begin
                  s1_valid_in = 1'b1;
                  s1_beat_in  = '{status: ST_FULL, value: '0};
               end else begin
                  mem_we = 1'b1;
                  occ_in = occ_ff + CNT_W'(1);
                  if (op == OP_PUSH_FRONT) begin
                     head_in  = head_dec;
                     mem_addr = head_dec;
                  end else begin
                     mem_addr = back_slot;
                  end
               end
            end
            OP_SIZE: begin
               s1_valid_in = 1'b1;
               s1_beat_in  = '{status: ST_OK, value: DATA_W'(occ_ff)};
            end
            OP_EMPTY: begin
               s1_valid_in = 1'b1;
               s1_beat_in  = '{status: ST_OK, value: DATA_W'(is_empty)};
            end
            OP_POP_FRONT, OP_POP_BACK, OP_FRONT, OP_BACK: begin
               s1_valid_in = 1'b1;
               if (is_empty) begin
                  s1_beat_in = '{status: ST_EMPTY, value: '1};
               end else begin
                  mem_re         = 1'b1;
                  s1_from_mem_in = 1'b1;
                  mem_addr       = (op inside {OP_POP_FRONT, OP_FRONT}) ? head_ff : back_slot;
                  if (op == OP_POP_FRONT) begin
                     head_in = head_inc;
                     occ_in  = occ_dec;
                  end else if (op == OP_POP_BACK) begin
                     occ_in  = occ_dec;
                  end
               end
            end
            default: begin
               s1_valid_in = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff     <= '0;
         occ_ff      <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         head_ff     <= head_in;
         occ_ff      <= occ_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_from_mem_ff <= s1_from_mem_in;
      s1_beat_ff     <= s1_beat_in;
   end

   // entry store, single port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[mem_addr] <= req_tdata;
      end
      if (mem_re) begin
         rd_data_ff <= store_mem[mem_addr];
      end
   end

   assign fifo_in_beat = '{status: s1_beat_ff.status,
                           value:  s1_from_mem_ff ? rd_data_ff : s1_beat_ff.value};

   // room for the beat in flight plus the one that a new request may add
   assign credit_sum = {1'b0, fifo_count} + (RSP_CNT_W + 1)'(s1_valid_ff);
   assign req_tready = (credit_sum < (RSP_CNT_W + 1)'(RSP_DEPTH));

   deq_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_valid_ff),
      .in_beat   (fifo_in_beat),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_beat  (fifo_out_beat),
      .count     (fifo_count)
   );

   assign rsp_tdata = fifo_out_beat.value;
   assign rsp_tuser = fifo_out_beat.status;

   a_occ_bound : assert property (@(posedge clock) disable iff (reset)
      occ_ff <= FULL_CNT)
      else $error("occupancy beyond depth");

   a_head_bound : assert property (@(posedge clock) disable iff (reset)
      head_ff <= LAST_IDX)
      else $error("head index beyond depth");

   a_push_grows : assert property (@(posedge clock) disable iff (reset)
      req_fire && (op == OP_PUSH_FRONT || op == OP_PUSH_BACK) && !is_full
      |=> occ_ff == $past(occ_ff) + CNT_W'(1))
      else $error("accepted push did not grow the queue");

   a_beat_has_request : assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |-> $past(req_fire))
      else $error("result beat without an accepted request");

endmodule

`default_nettype wire

>>> bench/double_ended_queue_engine_tb.sv
// self-checking testbench of the double-ended queue engine with its own deque predictor
`timescale 1ns / 1ps

module double_ended_queue_engine_tb;
   import deq_pkg::*;

   localparam int unsigned DEPTH          = DEPTH_DEFAULT;
   localparam int          WATCHDOG_LIMIT = 5000;
   localparam int          HOLD_CYCLES    = 300;
   localparam int          REPORT_LIMIT   = 100;
   localparam int          STIM_ROWS      = 22;

   typedef enum logic [1:0] {
      ROW_PREDICTED,
      ROW_NO_RESULT,
      ROW_FIXED
   } row_kind_type;

   typedef struct packed {
      row_kind_type        kind;
      logic [OP_W-1:0]     op;
      logic [DATA_W-1:0]   word;
      logic [DATA_W-1:0]   value;
      logic [STATUS_W-1:0] status;
   } stim_row_type;

   // fixed expectations only where obvious; the rest goes through the predictor
   localparam stim_row_type STIM_TABLE [STIM_ROWS] = '{
      '{ROW_FIXED,     OP_SIZE,       32'h0000_0000, 32'd0,         ST_OK},
      '{ROW_FIXED,     OP_EMPTY,      32'hFFFF_FFFF, 32'd1,         ST_OK},
      '{ROW_FIXED,     OP_POP_FRONT,  32'h0000_0000, 32'hFFFF_FFFF, ST_EMPTY},
      '{ROW_FIXED,     OP_POP_BACK,   32'hFFFF_FFFF, 32'hFFFF_FFFF, ST_EMPTY},
      '{ROW_FIXED,     OP_FRONT,      32'h0000_0000, 32'hFFFF_FFFF, ST_EMPTY},
      '{ROW_FIXED,     OP_BACK,       32'hFFFF_FFFF, 32'hFFFF_FFFF, ST_EMPTY},
      '{ROW_NO_RESULT, OP_PUSH_FRONT, 32'h7FFF_FFFF, 32'd0,         ST_OK},
      '{ROW_NO_RESULT, OP_PUSH_BACK,  32'h8000_0000, 32'd0,         ST_OK},
      '{ROW_NO_RESULT, OP_PUSH_FRONT, 32'hFFFF_FFFF, 32'd0,         ST_OK},
      '{ROW_NO_RESULT, OP_PUSH_BACK,  32'h0000_0000, 32'd0,         ST_OK},
      '{ROW_FIXED,     OP_SIZE,       32'hFFFF_FFFF, 32'd4,         ST_OK},
      '{ROW_FIXED,     OP_EMPTY,      32'h0000_0000, 32'd0,         ST_OK},
      '{ROW_PREDICTED, OP_FRONT,      32'h0000_0000, 32'd0,         ST_OK},
      '{ROW_PREDICTED, OP_BACK,       32'hFFFF_FFFF, 32'd0,         ST_OK},
      '{ROW_PREDICTED, OP_POP_FRONT,  32'h0000_0000, 32'd0,         ST_OK},
      '{ROW_PREDICTED, OP_POP_BACK,   32'hFFFF_FFFF, 32'd0,         ST_OK},
      '{ROW_PREDICTED, OP_POP_FRONT,  32'h0000_0000, 32'd0,         ST_OK},
      '{ROW_PREDICTED, OP_POP_BACK,   32'hFFFF_FFFF, 32'd0,         ST_OK},
      '{ROW_FIXED,     OP_POP_BACK,   32'h0000_0000, 32'hFFFF_FFFF, ST_EMPTY},
      '{ROW_NO_RESULT, OP_PUSH_BACK,  32'hA5A5_A5A5, 32'd0,         ST_OK},
      '{ROW_PREDICTED, OP_POP_FRONT,  32'hFFFF_FFFF, 32'd0,         ST_OK},
      '{ROW_FIXED,     OP_EMPTY,      32'h0000_0000, 32'd1,         ST_OK}
   };

   logic                clock;
   logic                reset;
   logic                req_tvalid;
   logic                req_tready;
   logic [DATA_W-1:0]   req_tdata;   // [31:0] push_value
   logic [OP_W-1:0]     req_tuser;   // [2:0] req_type
   logic                rsp_tvalid;
   logic                rsp_tready;
   logic [DATA_W-1:0]   rsp_tdata;   // [31:0] result_value
   logic [STATUS_W-1:0] rsp_tuser;   // [1:0] status

   logic [DATA_W-1:0] model_words [DEPTH];
   int unsigned       model_head;
   int unsigned       model_count;

   rsp_beat_type pending_results [$];
   rsp_beat_type want_beat;

   int  sender_idle_pct;
   int  receiver_stall_pct;
   bit  hold_ask;
   bit  hold_taken;
   int  hold_left;
   int  mismatches;
   int  beats_checked;
   int  requests_sent;
   int  quiet_cycles;

   double_ended_queue_engine #(
      .DEPTH(DEPTH)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // deque predictor: returns 1 when the request yields a result beat
   function automatic bit deque_step(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] word,
                                     output rsp_beat_type beat);
      int unsigned pos;
      beat.value  = '0;
      beat.status = ST_OK;
      case (op)
         OP_PUSH_FRONT, OP_PUSH_BACK: begin
            if (model_count >= DEPTH) begin
               beat.status = ST_FULL;
               return 1'b1;
            end
            if (op == OP_PUSH_FRONT) begin
               model_head = (model_head == 0) ? DEPTH - 1 : model_head - 1;
               model_words[model_head] = word;
            end else begin
               model_words[(model_head + model_count) % DEPTH] = word;
            end
            model_count++;
            return 1'b0;
         end
         OP_SIZE: begin
            beat.value = DATA_W'(model_count);
            return 1'b1;
         end
         OP_EMPTY: begin
            beat.value = (model_count == 0) ? 32'd1 : 32'd0;
            return 1'b1;
         end
         default: begin
            if (model_count == 0) begin
               beat.value  = 32'hFFFF_FFFF;
               beat.status = ST_EMPTY;
               return 1'b1;
            end
            if (op == OP_POP_FRONT || op == OP_FRONT)
               pos = model_head;
            else
               pos = (model_head + model_count - 1) % DEPTH;
            beat.value = model_words[pos];
            if (op == OP_POP_FRONT) begin
               model_head = (model_head + 1 >= DEPTH) ? 0 : model_head + 1;
               model_count--;
            end else if (op == OP_POP_BACK) begin
               model_count--;
            end
            return 1'b1;
         end
      endcase
   endfunction

   function automatic void queue_result(input rsp_beat_type beat);
      pending_results = {pending_results, beat};
   endfunction

   function automatic logic [OP_W-1:0] any_push();
      return $urandom_range(1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
   endfunction

   function automatic logic [OP_W-1:0] any_pop();
      return $urandom_range(1) ? OP_POP_BACK : OP_POP_FRONT;
   endfunction

   function automatic logic [OP_W-1:0] any_query();
      case ($urandom_range(3))
         0:       return OP_SIZE;
         1:       return OP_EMPTY;
         2:       return OP_FRONT;
         default: return OP_BACK;
      endcase
   endfunction

   task automatic set_idling(input int mode);
      case (mode)
         1:       begin sender_idle_pct = 79; receiver_stall_pct = 0;  end
         2:       begin sender_idle_pct = 0;  receiver_stall_pct = 79; end
         3:       begin sender_idle_pct = 31; receiver_stall_pct = 31; end
         default: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
      endcase
   endtask

   task automatic send_beat(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] word);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= word;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      requests_sent++;
   endtask

   task automatic issue(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] word);
      rsp_beat_type beat;
      send_beat(op, word);
      if (deque_step(op, word, beat)) queue_result(beat);
   endtask

   // result checker and receiver readiness
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("%0t: unexpected result beat, expected none, actual value %h status %0d",
                        $time, rsp_tdata, rsp_tuser);
         end else begin
            want_beat = pending_results[0];
            pending_results.delete(0);
            beats_checked++;
            if (rsp_tdata !== want_beat.value) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT)
                  $display("%0t: result value mismatch, expected %h, actual %h",
                           $time, want_beat.value, rsp_tdata);
            end
            if (rsp_tuser !== want_beat.status) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT)
                  $display("%0t: status mismatch, expected %0d, actual %0d",
                           $time, want_beat.status, rsp_tuser);
            end
         end
      end
      if (hold_ask && !hold_taken) begin
         hold_taken = 1'b1;
         hold_left  = HOLD_CYCLES;
      end
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: watchdog, no beat moved for %0d cycles", $time, quiet_cycles);
         $display("== FAIL ==");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      logic [OP_W-1:0] op;
      rsp_beat_type    beat;
      rsp_beat_type    fixed;
      bit              gives;
      int              r;
      int              push_pct;

      reset       <= 1'b1;
      req_tvalid  <= 1'b0;
      req_tdata   <= '0;
      req_tuser   <= OP_SIZE;
      model_head  = 0;
      model_count = 0;
      hold_ask    = 1'b0;
      requests_sent = 0;
      set_idling(0);
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed rows
      for (int i = 0; i < STIM_ROWS; i++) begin
         send_beat(STIM_TABLE[i].op, STIM_TABLE[i].word);
         gives = deque_step(STIM_TABLE[i].op, STIM_TABLE[i].word, beat);
         case (STIM_TABLE[i].kind)
            ROW_FIXED: begin
               fixed.value  = STIM_TABLE[i].value;
               fixed.status = STIM_TABLE[i].status;
               queue_result(fixed);
            end
            ROW_NO_RESULT: ;
            default: if (gives) queue_result(beat);
         endcase
      end

      // long receiver hold-off with the sender still offering queries
      repeat (4) issue(any_push(), $urandom);
      hold_ask = 1'b1;
      repeat (60) issue(any_query(), $urandom);

      // random traffic, alternating between growing and shrinking stretches
      for (int phase = 0; phase < 4; phase++) begin
         set_idling(phase);
         for (int n = 0; n < 120; n++) begin
            push_pct = ((n / 25) % 2 == 0) ? 60 : 25;
            r = $urandom_range(99);
            if (r < push_pct)
               op = any_push();
            else if (r < 85)
               op = any_pop();
            else
               op = any_query();
            issue(op, $urandom);
         end
      end

      // a few more pushes under receiver stalls, then drain past empty
      set_idling(2);
      repeat (8) issue(any_push(), $urandom);
      set_idling(3);
      while (model_count > 0) issue(any_pop(), $urandom);
      repeat (6) issue($urandom_range(1) ? any_pop() : any_query(), $urandom);

      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("ran %0d requests, %0d result beats checked, %0d mismatches",
               requests_sent, beats_checked, mismatches);
      $display("covered pops and peeks on an empty queue, head wrap, a %0d-cycle hold-off",
               HOLD_CYCLES);
      if (mismatches == 0 && pending_results.size() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
